// ----- src/tks_pkg.sv -----
// Package for the top-k selector: entry and control types, field widths and constants.
// Used by tks_cell and top_k_selector_top; depends on nothing else.
package tks_pkg;

   // Field widths of the payload.
   localparam int RATING_W    = 16;
   localparam int INDEX_W     = 10;
   localparam int TOP_COUNT_W = 5;

   // Reset value of the top-count register.
   localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 5'd10;

   // One kept entry without its valid bit.
   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [RATING_W-1:0] rating;
   } entry_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic insert;  // rank a new item into the chain
      logic drain;   // move every entry one cell toward the head
      logic clear;   // invalidate every entry
   } cell_ctrl_type;

   // Sequencer states.
   typedef enum logic {
      ST_GATHER,
      ST_DRAIN
   } tks_state_type;

endpackage

// ----- src/top_k_selector_top.sv -----
// Top level of the streaming top-k selector: sequencer, item counter and the cell chain.
// Depends on tks_pkg and tks_cell.
//
//   Channel   Ports                                         Transfer when
//   request   start, busy, req_rating, req_last             start high, busy low
//   response  rsp_strobe, rsp_item_index, rsp_rank_rating,   rsp_strobe high
//             rsp_final_res
//   config    csr_we, csr_wdata (top count)                 csr_we high
//
// An item that is not the last of its set is ranked into the chain when it is accepted.
// A last item is ranked the same way; then the n reported entries (at most MAX_KEPT) leave
// cell 0 one per cycle, best first; busy is high while they leave.
// Synchronous active-high reset empties the chain, zeroes the counter, sets top count to 10.
// The receiver cannot stall: each result is shown for exactly one cycle.
module top_k_selector_top
   import tks_pkg::*;
#(
   parameter int MAX_KEPT  = 16,
   parameter int MAX_ITEMS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [RATING_W-1:0]    req_rating,
   input  logic                   req_last,
   output logic                   rsp_strobe,
   output logic [INDEX_W-1:0]     rsp_item_index,
   output logic [RATING_W-1:0]    rsp_rank_rating,
   output logic                   rsp_final_res,
   input  logic                   csr_we,
   input  logic [TOP_COUNT_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int LIM_W = $clog2(MAX_KEPT + 1);
   localparam int CMP_W = (LIM_W > TOP_COUNT_W) ? LIM_W : TOP_COUNT_W;

   tks_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [TOP_COUNT_W-1:0]     top_count_ff;
   logic [LIM_W-1:0]           limit_ff, limit_in;
   logic [LIM_W-1:0]           emit_ff, emit_in;
   logic [CMP_W-1:0]           top_wide;
   logic [CMP_W-1:0]           limit_wide;
   logic [CNT_W+INDEX_W-1:0]   count_wide;
   logic                       accept;
   logic                       ranked;
   logic                       final_entry;
   cell_ctrl_type              ctrl;
   entry_type                  new_entry;

   // Chain wiring: position 0 is above the head, position MAX_KEPT is the tail cell.
   logic      take_chain  [MAX_KEPT+1];
   logic      valid_chain [MAX_KEPT+1];
   entry_type entry_chain [MAX_KEPT+1];
   logic [MAX_KEPT:0] valid_vec;

   assign accept = start && !busy;
   assign ranked = count_ff < CNT_W'(MAX_ITEMS);

   // The index field keeps the low bits of the arrival count.
   assign count_wide          = {{INDEX_W{1'b0}}, count_ff};
   assign new_entry.index     = count_wide[INDEX_W-1:0];
   assign new_entry.rating    = req_rating;

   // Top-count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TOP_COUNT_RESET;
      end else if (csr_we) begin
         top_count_ff <= csr_wdata;
      end
   end

   // Report limit: zero acts as one, anything above the chain length as the chain length.
   always_comb begin
      top_wide = CMP_W'(top_count_ff);
      if (top_wide == '0) begin
         limit_wide = CMP_W'(1);
      end else if (top_wide > CMP_W'(MAX_KEPT)) begin
         limit_wide = CMP_W'(MAX_KEPT);
      end else begin
         limit_wide = top_wide;
      end
   end

   // The chain head carries the next result; it is the last one when the limit is
   // reached or no further entry is kept.
   assign final_entry = (emit_ff + LIM_W'(1) == limit_ff) || !valid_vec[1];

   // Sequencer: next state, counters and cell control.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      limit_in    = limit_ff;
      emit_in     = emit_ff;
      ctrl        = '0;
      busy        = 1'b0;
      rsp_strobe  = 1'b0;
      case (state_ff)
         ST_GATHER: begin
            if (accept) begin
               ctrl.insert = ranked;
               if (ranked) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_last) begin
                  count_in = '0;
                  limit_in = limit_wide[LIM_W-1:0];
                  emit_in  = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            busy       = 1'b1;
            rsp_strobe = valid_chain[1];
            if (!valid_chain[1] || final_entry) begin
               ctrl.clear = 1'b1;
               state_in   = ST_GATHER;
            end else begin
               ctrl.drain = 1'b1;
               emit_in    = emit_ff + LIM_W'(1);
            end
         end
         default: begin
            state_in = ST_GATHER;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_GATHER;
         count_ff <= '0;
         limit_ff <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         limit_ff <= limit_in;
         emit_ff  <= emit_in;
      end
   end

   // Chain ends: nothing is taken above the head, the tail drains in an empty entry.
   assign take_chain[0]         = 1'b0;
   assign valid_chain[0]        = 1'b0;
   assign entry_chain[0]        = new_entry;

   // The row of cells.
   for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
      logic      down_valid;
      entry_type down_entry;

      if (g == MAX_KEPT - 1) begin : g_tail
         assign down_valid = 1'b0;
         assign down_entry = entry_chain[g+1];
      end else begin : g_mid
         assign down_valid = valid_chain[g+2];
         assign down_entry = entry_chain[g+2];
      end

      tks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_entry  (new_entry),
         .up_take    (take_chain[g]),
         .up_valid   (valid_chain[g]),
         .up_entry   (entry_chain[g]),
         .down_valid (down_valid),
         .down_entry (down_entry),
         .take       (take_chain[g+1]),
         .valid      (valid_chain[g+1]),
         .entry      (entry_chain[g+1])
      );
   end

   // Flattened valid bits for the checks; bit 0 is the head cell.
   for (genvar v = 0; v < MAX_KEPT; v++) begin : g_valid
      assign valid_vec[v] = valid_chain[v+1];
   end
   assign valid_vec[MAX_KEPT] = 1'b0;

   // Result ports come straight from the head cell.
   assign rsp_item_index  = entry_chain[1].index;
   assign rsp_rank_rating = entry_chain[1].rating;
   assign rsp_final_res   = final_entry;

`ifndef SYNTHESIS
   // Kept entries always fill the chain from the head without gaps.
   assert property (@(posedge clock) disable iff (reset)
      ((valid_vec >> 1) & ~valid_vec) == '0)
      else $error("kept entries are not contiguous from the head");

   // Results appear only while draining.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside the drain phase");

   // A last item starts the drain, and the flagged result ends it with an empty chain.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (busy && valid_vec[0]))
      else $error("last item did not start a drain");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_final_res) |=> (!busy && valid_vec == '0))
      else $error("drain did not end after the flagged result");
`endif

endmodule

// ----- src/tks_cell.sv -----
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
// Depends on tks_pkg for the entry and control types.
module tks_cell
   import tks_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  logic          up_take,
   input  logic          up_valid,
   input  entry_type     up_entry,
   input  logic          down_valid,
   input  entry_type     down_entry,
   output logic          take,
   output logic          valid,
   output entry_type     entry
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;

   // A new item goes above this entry when the slot is empty or strictly worse.
   // Equal ratings keep the earlier arrival on top.
   assign take = !valid_ff || (new_entry.rating > entry_ff.rating);

   // Next entry: cleared on clear; on insert, shift down from above or take the new item; shift up from below on drain.
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.insert) begin
         if (up_take) begin
            valid_in = up_valid;
            entry_in = up_entry;
         end else if (take) begin
            valid_in = 1'b1;
            entry_in = new_entry;
         end
      end else if (ctrl.drain) begin
         valid_in = down_valid;
         entry_in = down_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

// ----- dv/top_k_selector_top_test.sv -----
// Testbench for top_k_selector_top: drives sets of ratings and checks every reported entry.
// Depends on tks_pkg and the RTL of top_k_selector_top; a scoreboard class predicts the report.
`timescale 1ns / 100ps

module top_k_selector_top_test;
   import tks_pkg::*;

   localparam int KEEP_DEPTH   = 16;
   localparam int SET_LIMIT    = 1024;
   localparam int CLOCK_PERIOD = 12;
   localparam int DRAIN_PAD    = 4;
   localparam int ITEM_TARGET  = 440;

   // One reported entry of the ranking.
   typedef struct {
      logic [INDEX_W-1:0]  item_index;
      logic [RATING_W-1:0] rank_rating;
      logic                final_res;
   } pick_type;

   // Scoreboard: keeps its own ranked list and the queue of entries still to be reported.
   class top_k_board;
      logic [RATING_W-1:0]    list_rating [KEEP_DEPTH];
      int unsigned            list_index [KEEP_DEPTH];
      int unsigned            list_fill;
      int unsigned            arrivals;
      logic [TOP_COUNT_W-1:0] report_count;
      pick_type               expected_picks [$];
      int unsigned            mismatches;

      function new();
         empty_list();
         report_count = TOP_COUNT_RESET;
         mismatches = 0;
      endfunction

      function void empty_list();
         foreach (list_rating[i]) begin
            list_rating[i] = '0;
            list_index[i] = 0;
         end
         list_fill = 0;
         arrivals = 0;
      endfunction

      function void set_report_count(input logic [TOP_COUNT_W-1:0] value);
         report_count = value;
      endfunction

      // Ranks one accepted item; on the last item of a set, queues the report and clears.
      function void rank_item(input logic [RATING_W-1:0] rating, input logic last);
         int unsigned pos;
         int unsigned k;
         int unsigned limit;
         int unsigned n;
         pick_type    pick;
         if (arrivals < SET_LIMIT) begin
            // Ties stay behind the earlier arrival.
            pos = 0;
            while (pos < list_fill && list_rating[pos] >= rating) pos++;
            if (pos < KEEP_DEPTH) begin
               k = (list_fill < KEEP_DEPTH) ? list_fill : KEEP_DEPTH - 1;
               while (k > pos) begin
                  list_rating[k] = list_rating[k-1];
                  list_index[k] = list_index[k-1];
                  k--;
               end
               list_rating[pos] = rating;
               list_index[pos] = arrivals;
               if (list_fill < KEEP_DEPTH) list_fill++;
            end
            arrivals++;
         end
         if (last) begin
            // A count of zero reports one entry; counts above the list depth report all.
            limit = (report_count == 0) ? 1 : report_count;
            if (limit > KEEP_DEPTH) limit = KEEP_DEPTH;
            n = (list_fill < limit) ? list_fill : limit;
            for (int i = 0; i < n; i++) begin
               pick.item_index = INDEX_W'(list_index[i]);
               pick.rank_rating = list_rating[i];
               pick.final_res = (i + 1 == n);
               expected_picks.push_back(pick);
            end
            empty_list();
         end
      endfunction

      // Compares one reported entry with the oldest one expected.
      function void check_pick(input logic [INDEX_W-1:0] item_index,
                               input logic [RATING_W-1:0] rank_rating,
                               input logic final_res);
         pick_type want;
         if (expected_picks.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected entry: index %0d rating %h final %b",
                        item_index, rank_rating, final_res);
            mismatches++;
         end else begin
            want = expected_picks.pop_front();
            if (item_index !== want.item_index || rank_rating !== want.rank_rating ||
                final_res !== want.final_res) begin
               if (mismatches < 10)
                  $display("entry mismatch: got index %0d rating %h final %b, %s %0d %h %b",
                           item_index, rank_rating, final_res, "expected",
                           want.item_index, want.rank_rating, want.final_res);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_picks.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [RATING_W-1:0]    req_rating = '0;
   logic                   req_last = 1'b0;
   logic                   rsp_strobe;
   logic [INDEX_W-1:0]     rsp_item_index;
   logic [RATING_W-1:0]    rsp_rank_rating;
   logic                   rsp_final_res;
   logic                   csr_we = 1'b0;
   logic [TOP_COUNT_W-1:0] csr_wdata = '0;

   top_k_board board = new();
   int         items_sent = 0;

   top_k_selector_top #(
      .MAX_KEPT  (KEEP_DEPTH),
      .MAX_ITEMS (SET_LIMIT)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_rating      (req_rating),
      .req_last        (req_last),
      .rsp_strobe      (rsp_strobe),
      .rsp_item_index  (rsp_item_index),
      .rsp_rank_rating (rsp_rank_rating),
      .rsp_final_res   (rsp_final_res),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Each strobed entry is one transfer; the receiver never holds it off.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_pick(rsp_item_index, rsp_rank_rating, rsp_final_res);
   end

   // Presents one item and waits for its transfer.
   task automatic send_item(input logic [RATING_W-1:0] rating, input logic last);
      start <= 1'b1;
      req_rating <= rating;
      req_last <= last;
      do @(posedge clock); while (busy);
      board.rank_item(rating, last);
      items_sent++;
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap(input bit quiet);
      if (!quiet && $urandom_range(0, 9) == 0) hold_off($urandom_range(1, 6));
   endtask

   // Stops sending until every expected entry has come and the chain has gone quiet.
   task automatic settle();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic write_report_count(input logic [TOP_COUNT_W-1:0] value);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_report_count(value);
   endtask

   // Mix of wide random ratings, coarse values that tie often, and both extremes.
   function automatic logic [RATING_W-1:0] random_rating();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return RATING_W'($urandom);
         5, 6, 7:       return RATING_W'($urandom_range(0, 4) << 13);
         8:             return RATING_W'(16'hFFFF - $urandom_range(0, 3));
         default:       return RATING_W'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [TOP_COUNT_W-1:0] random_count();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return TOP_COUNT_W'(1);
         2:       return TOP_COUNT_W'(KEEP_DEPTH);
         3:       return TOP_COUNT_W'($urandom_range(KEEP_DEPTH + 1, 31));
         4:       return TOP_COUNT_W'($urandom_range(0, 31));
         default: return TOP_COUNT_W'($urandom_range(2, KEEP_DEPTH - 1));
      endcase
   endfunction

   // One complete set; optionally the count changes halfway through it.
   task automatic run_set(input int length, input bit mid_write);
      for (int i = 0; i < length; i++) begin
         if (mid_write && i == length / 2) write_report_count(random_count());
         send_item(random_rating(), i == length - 1);
         maybe_gap(items_sent >= 180 && items_sent < 330);
      end
   endtask

   initial begin
      int length;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: a one-item set, ties at the top rating, and both count extremes.
      send_item(16'h0000, 1'b1);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'hFFFF, 1'b0);
      send_item(16'h1234, 1'b1);
      write_report_count(5'd0);
      send_item(16'h0005, 1'b0);
      send_item(16'h0009, 1'b0);
      send_item(16'h0009, 1'b1);
      write_report_count(5'd31);
      for (int i = 0; i < KEEP_DEPTH + 1; i++)
         send_item((i % 3 == 0) ? 16'h8000 : RATING_W'($urandom), i == KEEP_DEPTH);

      // Random sets, mostly short, with count changes between and inside sets.
      write_report_count(5'd1);
      run_set(6, 1'b0);
      write_report_count(5'(KEEP_DEPTH));
      run_set(20, 1'b0);
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: length = $urandom_range(1, 12);
            14, 15, 16, 17, 18: length = $urandom_range(13, 40);
            default: length = $urandom_range(41, 90);
         endcase
         if ($urandom_range(0, 5) == 0) write_report_count(random_count());
         run_set(length, length > 2 && $urandom_range(0, 19) == 0);
      end

      settle();
      repeat (20) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(CLOCK_PERIOD * 200000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
